FILE: rtl/pse_pkg.sv
// Shared types, constants and helper functions of the PNG stored-deflate encoder.
package pse_pkg;

  // Depth of the pixel queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // Modulus of the Adler-32 sums.
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // Header byte positions that need special handling.
  localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
  localparam logic [5:0] HDR_IDAT_LEN  = 6'd33;
  localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
  localparam logic [5:0] HDR_LAST      = 6'd42;
  localparam logic [5:0] BLK_LAST      = 6'd4;
  localparam logic [5:0] TAIL_IEND_TYPE = 6'd12;
  localparam logic [5:0] TAIL_LAST     = 6'd19;

  // Head of the pixel queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_item_t;

  // What an emitted byte does to the running chunk CRC.
  typedef enum logic [1:0] {
    CRC_KEEP    = 2'd0,
    CRC_ADD     = 2'd1,
    CRC_RESTART = 2'd2
  } crc_op_t;

  // One byte through the CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Byte idx of a big-endian 32-bit word, idx 0 being the most significant.
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = w[31:24];
      2'd1: r = w[23:16];
      2'd2: r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/pse_queue.sv
// Front end: accepts pixel byte requests and holds them in a short queue.
module pse_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] pixel_byte
  output pse_pkg::q_item_t head,
  input  logic             pop
);

  logic [7:0] mem [pse_pkg::QUEUE_DEPTH];
  logic [pse_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [pse_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [pse_pkg::QUEUE_PTR_W:0]   count;
  logic push;
  logic do_pop;

  assign s_tready = (count != (pse_pkg::QUEUE_PTR_W+1)'(pse_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= s_tdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/pse_emit.sv
// Back end: sequences the PNG byte stream, with CRC-32, Adler-32 and length math.
module pse_emit #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_HEIGHT       = 4096,
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [12:0]      image_width,
  input  logic [12:0]      image_height,
  input  pse_pkg::q_item_t head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(4 * MAX_WIDTH + 1);
  localparam longint RAW_MAX = longint'(MAX_HEIGHT) * (4 * longint'(MAX_WIDTH) + 1);
  localparam int RW = $clog2(RAW_MAX + 1);
  localparam int NW = $clog2(RAW_MAX + longint'(STORED_BLOCK_MAX));

  // Reciprocal of the block size, exact for every numerator below 2**NW.
  localparam int DLOG = $clog2(STORED_BLOCK_MAX);
  localparam int SH   = NW + DLOG;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(STORED_BLOCK_MAX) - 1) /
                             longint'(STORED_BLOCK_MAX);
  localparam int MW = $clog2(RECIP + 1);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  // Steps of the length calculation.
  localparam logic [1:0] CALC_LOAD = 2'd0;
  localparam logic [1:0] CALC_MUL  = 2'd1;
  localparam logic [1:0] CALC_LEN  = 2'd2;
  localparam logic [1:0] CALC_IDLE = 2'd3;

  typedef enum logic [3:0] {
    ST_DATA = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_BLK  = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t state;
  logic [5:0]    step;
  logic          in_image;
  logic          need_filter;
  logic [DW-1:0] lat_w;
  logic [HW-1:0] lat_h;
  logic [CW-1:0] col;
  logic [15:0]   block_left;
  logic [15:0]   blk_cnt;
  logic          blk_final;
  logic [RW-1:0] raw_left;
  logic [31:0]   idat_length;
  logic [15:0]   adler_a;
  logic [15:0]   adler_b;
  logic [31:0]   crc;

  // Length calculation: raw count, then block count by reciprocal multiplication.
  logic [1:0]       calc_cnt;
  logic             calc_done;
  logic [NW-1:0]    div_num;
  logic [NW-1:0]    div_q;
  logic [NW+MW-1:0] div_prod;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Clamped dimensions for a new image.
  logic [DW-1:0] w_cl;
  logic [HW-1:0] h_cl;
  always_comb begin
    if (image_width == '0) begin
      w_cl = DW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_cl = DW'(MAX_WIDTH);
    end else begin
      w_cl = DW'(image_width);
    end
    if (image_height == '0) begin
      h_cl = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(image_height);
    end
  end

  // Raw byte count of the image: height times one row plus its filter byte.
  logic [RW-1:0] raw_prod;
  assign raw_prod = RW'(lat_h) * RW'({lat_w, 2'b01});

  // Rounded-up block count as a product with the reciprocal.
  assign div_prod = (NW+MW)'(div_num) * (NW+MW)'(RECIP_M);

  // Adler-32 update for the raw byte in flight.
  logic [7:0]  raw_byte;
  logic [16:0] a_sum;
  logic [16:0] a_mod;
  logic [16:0] b_sum;
  logic [16:0] b_mod;
  assign raw_byte = need_filter ? 8'd0 : head.data;
  assign a_sum = {1'b0, adler_a} + 17'(raw_byte);
  assign a_mod = (a_sum >= pse_pkg::ADLER_MOD) ? a_sum - pse_pkg::ADLER_MOD : a_sum;
  assign b_sum = {1'b0, adler_b} + a_mod;
  assign b_mod = (b_sum >= pse_pkg::ADLER_MOD) ? b_sum - pse_pkg::ADLER_MOD : b_sum;

  // Column wrap at the end of a row.
  logic [CW-1:0] col_inc;
  logic          row_end;
  assign col_inc = col + 1'b1;
  assign row_end = ((DW+2)'(col_inc) == {lat_w, 2'b00});

  // Header, block header and trailer bytes by step.
  logic [31:0] crc_out;
  assign crc_out = ~crc;

  logic [7:0]        hdr_byte;
  pse_pkg::crc_op_t  hdr_op;
  always_comb begin
    hdr_op = pse_pkg::CRC_ADD;
    unique case (step)
      6'd0: hdr_byte = 8'h89;
      6'd1: hdr_byte = 8'h50;
      6'd2: hdr_byte = 8'h4e;
      6'd3: hdr_byte = 8'h47;
      6'd4: hdr_byte = 8'h0d;
      6'd5: hdr_byte = 8'h0a;
      6'd6: hdr_byte = 8'h1a;
      6'd7: hdr_byte = 8'h0a;
      6'd8, 6'd9, 6'd10: hdr_byte = 8'h00;
      6'd11: hdr_byte = 8'd13;
      6'd12: hdr_byte = 8'h49;
      6'd13: hdr_byte = 8'h48;
      6'd14: hdr_byte = 8'h44;
      6'd15: hdr_byte = 8'h52;
      6'd16, 6'd17, 6'd18, 6'd19: hdr_byte = pse_pkg::be_byte(32'(lat_w), step[1:0]);
      6'd20, 6'd21, 6'd22, 6'd23: hdr_byte = pse_pkg::be_byte(32'(lat_h), step[1:0]);
      6'd24: hdr_byte = 8'd8;
      6'd25: hdr_byte = 8'd6;
      6'd26, 6'd27, 6'd28: hdr_byte = 8'd0;
      6'd29, 6'd30, 6'd31, 6'd32:
        hdr_byte = pse_pkg::be_byte(crc_out, 2'(step - 6'd29));
      6'd33, 6'd34, 6'd35, 6'd36:
        hdr_byte = pse_pkg::be_byte(idat_length, 2'(step - 6'd33));
      6'd37: hdr_byte = 8'h49;
      6'd38: hdr_byte = 8'h44;
      6'd39: hdr_byte = 8'h41;
      6'd40: hdr_byte = 8'h54;
      6'd41: hdr_byte = 8'h78;
      6'd42: hdr_byte = 8'h01;
      default: hdr_byte = 8'h00;
    endcase
    if (step == pse_pkg::HDR_IHDR_TYPE || step == pse_pkg::HDR_IDAT_TYPE) begin
      hdr_op = pse_pkg::CRC_RESTART;
    end else if (step < pse_pkg::HDR_IHDR_TYPE ||
                 (step >= 6'd29 && step < pse_pkg::HDR_IDAT_TYPE)) begin
      hdr_op = pse_pkg::CRC_KEEP;
    end
  end

  logic [7:0] blk_byte;
  always_comb begin
    unique case (step[2:0])
      3'd0: blk_byte = {7'd0, blk_final};
      3'd1: blk_byte = blk_cnt[7:0];
      3'd2: blk_byte = blk_cnt[15:8];
      3'd3: blk_byte = ~blk_cnt[7:0];
      default: blk_byte = ~blk_cnt[15:8];
    endcase
  end

  logic [7:0]       tail_byte;
  pse_pkg::crc_op_t tail_op;
  always_comb begin
    tail_op = pse_pkg::CRC_KEEP;
    unique case (step)
      6'd0, 6'd1, 6'd2, 6'd3:
        tail_byte = pse_pkg::be_byte({adler_b, adler_a}, step[1:0]);
      6'd4, 6'd5, 6'd6, 6'd7:
        tail_byte = pse_pkg::be_byte(crc_out, step[1:0]);
      6'd12: tail_byte = 8'h49;
      6'd13: tail_byte = 8'h45;
      6'd14: tail_byte = 8'h4e;
      6'd15: tail_byte = 8'h44;
      6'd16, 6'd17, 6'd18, 6'd19:
        tail_byte = pse_pkg::be_byte(crc_out, step[1:0]);
      default: tail_byte = 8'h00;
    endcase
    if (step < 6'd4 || (step > pse_pkg::TAIL_IEND_TYPE && step < 6'd16)) begin
      tail_op = pse_pkg::CRC_ADD;
    end else if (step == pse_pkg::TAIL_IEND_TYPE) begin
      tail_op = pse_pkg::CRC_RESTART;
    end
  end

  // Byte chosen for this cycle, and what it does.
  logic             emit;
  logic [7:0]       emit_byte;
  pse_pkg::crc_op_t emit_op;
  logic             emit_last;
  logic             emit_end;
  logic             head_wait;
  assign head_wait = (step == pse_pkg::HDR_IDAT_LEN) && !calc_done;

  always_comb begin
    emit      = 1'b0;
    emit_byte = raw_byte;
    emit_op   = pse_pkg::CRC_ADD;
    emit_last = 1'b0;
    emit_end  = 1'b0;
    pop       = 1'b0;
    unique case (state)
      ST_DATA: begin
        if (out_free && head.valid && in_image && block_left != '0) begin
          emit = 1'b1;
          if (!need_filter) begin
            pop       = 1'b1;
            emit_last = (raw_left != RW'(1));
          end
        end
      end
      ST_HEAD: begin
        emit      = out_free && !head_wait;
        emit_byte = hdr_byte;
        emit_op   = hdr_op;
      end
      ST_BLK: begin
        emit      = out_free;
        emit_byte = blk_byte;
      end
      default: begin
        emit      = out_free;
        emit_byte = tail_byte;
        emit_op   = tail_op;
        emit_last = (step == pse_pkg::TAIL_LAST);
        emit_end  = (step == pse_pkg::TAIL_LAST);
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
      m_tuser <= emit_end;
    end
  end

  // Running chunk CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= pse_pkg::CRC_INIT;
    end else if (emit) begin
      unique case (emit_op)
        pse_pkg::CRC_ADD:     crc <= pse_pkg::crc_byte(crc, emit_byte);
        pse_pkg::CRC_RESTART: crc <= pse_pkg::crc_byte(pse_pkg::CRC_INIT, emit_byte);
        default:              crc <= crc;
      endcase
    end
  end

  // Length calculation datapath: load, multiply, then the IDAT length.
  always_ff @(posedge clk) begin
    if (calc_cnt == CALC_LOAD) begin
      div_num <= NW'(raw_prod) + NW'(STORED_BLOCK_MAX - 1);
    end
    if (calc_cnt == CALC_MUL) begin
      div_q <= NW'(div_prod >> SH);
    end
    if (calc_cnt == CALC_LEN) begin
      idat_length <= 32'd6 + 32'(raw_left) + 32'(div_q) + (32'(div_q) << 2);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_DATA;
      step        <= '0;
      in_image    <= 1'b0;
      need_filter <= 1'b0;
      lat_w       <= DW'(1);
      lat_h       <= HW'(1);
      col         <= '0;
      block_left  <= '0;
      blk_cnt     <= '0;
      blk_final   <= 1'b0;
      raw_left    <= '0;
      adler_a     <= 16'd1;
      adler_b     <= '0;
      calc_cnt    <= CALC_IDLE;
      calc_done   <= 1'b0;
    end else begin
      if (calc_cnt == CALC_LOAD) begin
        raw_left <= raw_prod;
      end
      if (calc_cnt != CALC_IDLE) begin
        calc_cnt <= calc_cnt + 1'b1;
      end
      if (calc_cnt == CALC_LEN) begin
        calc_done <= 1'b1;
      end
      unique case (state)
        ST_DATA: begin
          if (out_free && head.valid) begin
            if (!in_image) begin
              // New image: latch dimensions and start the header.
              lat_w       <= w_cl;
              lat_h       <= h_cl;
              in_image    <= 1'b1;
              need_filter <= 1'b1;
              col         <= '0;
              block_left  <= '0;
              adler_a     <= 16'd1;
              adler_b     <= '0;
              calc_cnt    <= CALC_LOAD;
              calc_done   <= 1'b0;
              step        <= '0;
              state       <= ST_HEAD;
            end else if (block_left == '0) begin
              // Next raw byte opens a stored block.
              blk_final <= (32'(raw_left) <= 32'(STORED_BLOCK_MAX));
              blk_cnt   <= (32'(raw_left) > 32'(STORED_BLOCK_MAX)) ?
                           16'(STORED_BLOCK_MAX) : 16'(raw_left);
              step      <= '0;
              state     <= ST_BLK;
            end else begin
              adler_a    <= a_mod[15:0];
              adler_b    <= b_mod[15:0];
              block_left <= block_left - 1'b1;
              raw_left   <= raw_left - 1'b1;
              if (need_filter) begin
                need_filter <= 1'b0;
              end else begin
                if (row_end) begin
                  col         <= '0;
                  need_filter <= 1'b1;
                end else begin
                  col <= col_inc;
                end
                if (raw_left == RW'(1)) begin
                  step  <= '0;
                  state <= ST_TAIL;
                end
              end
            end
          end
        end
        ST_HEAD: begin
          if (emit) begin
            step <= step + 1'b1;
            if (step == pse_pkg::HDR_LAST) begin
              state <= ST_DATA;
            end
          end
        end
        ST_BLK: begin
          if (emit) begin
            step <= step + 1'b1;
            if (step == pse_pkg::BLK_LAST) begin
              block_left <= blk_cnt;
              state      <= ST_DATA;
            end
          end
        end
        default: begin
          if (emit) begin
            step <= step + 1'b1;
            if (step == pse_pkg::TAIL_LAST) begin
              in_image    <= 1'b0;
              need_filter <= 1'b0;
              col         <= '0;
              block_left  <= '0;
              state       <= ST_DATA;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/png_stored_deflate_encoder_core.sv
// Top level of the PNG encoder that wraps RGBA8 pixels in stored deflate blocks.
//
// Pixel bytes (R, G, B, A, raster order) enter on the s_ side and the complete
// PNG file leaves on the m_ side, at most one byte per cycle, held back by
// m_tready, the queue or the IDAT length: signature, IHDR, one IDAT with zlib
// header, stored blocks and Adler-32, then IEND. The output byte lane sets the
// rate: a pixel byte is one byte, a row start adds a filter byte, a block start
// adds five header bytes, an image's first byte adds 43 header bytes, and the
// last byte adds 20 trailer bytes. The output register and the four-entry pixel
// queue let requests keep arriving while results wait. Width and height are
// latched at the first byte of each image; write them only between images.
module png_stored_deflate_encoder_core #(
  parameter int MAX_WIDTH        = 4096,
  parameter int MAX_HEIGHT       = 4096,
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] pixel_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,    // run_last
  output logic        m_tuser,    // [0] image_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  logic [12:0] image_width;
  logic [12:0] image_height;
  pse_pkg::q_item_t head;
  logic pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  pse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  pse_emit #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .head         (head),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

endmodule

FILE: test/png_tb_pkg.sv
// Register indexes and result layout shared by the encoder testbench files.
package png_tb_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  // Indexes past the register list, which the block ignores.
  localparam logic [1:0] REG_SPARE0 = 2'd2;
  localparam logic [1:0] REG_SPARE1 = 2'd3;

  // One byte of the PNG stream as it should leave the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       image_end;
  } png_byte_t;

endpackage

FILE: test/png_stream_monitor.sv
// Monitor that predicts the PNG byte stream from accepted requests and checks the output.
module png_stream_monitor #(
  parameter int MAX_W     = 4096,
  parameter int MAX_H     = 4096,
  parameter int BLOCK_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          failures,
  output int          pending
);

  // Bytes of the PNG stream still due from the block, oldest first.
  png_tb_pkg::png_byte_t png_bytes_due[$];

  // Shadow of the encoder state.
  logic [12:0] reg_w, reg_h;
  logic [12:0] img_w, img_h;
  logic        in_image;
  logic [14:0] col;
  logic [15:0] blk_left;
  logic [26:0] raw_left;
  logic [31:0] idat_len;
  logic [31:0] adler_a, adler_b;
  logic [31:0] run_crc;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
    return c;
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] v, input int maxv);
    if (v == 0) return 13'd1;
    return (v > maxv) ? 13'(maxv) : v;
  endfunction

  task automatic due_byte(input logic [7:0] b, input logic in_crc);
    png_tb_pkg::png_byte_t item;
    item = '{b, 1'b0, 1'b0};
    png_bytes_due.insert(png_bytes_due.size(), item);
    if (in_crc) run_crc = crc_update(run_crc, b);
  endtask

  task automatic due_word(input logic [31:0] w, input logic in_crc);
    for (int i = 3; i >= 0; i--) due_byte(w[i*8 +: 8], in_crc);
  endtask

  task automatic due_chunk_type(input logic [31:0] tag);
    run_crc = 32'hffffffff;
    due_word(tag, 1'b1);
  endtask

  // Raw zlib data byte, opening a stored block first where one is needed.
  task automatic due_raw(input logic [7:0] b);
    logic [15:0] cnt;
    if (blk_left == 0) begin
      cnt = (raw_left > BLOCK_MAX) ? 16'(BLOCK_MAX) : raw_left[15:0];
      due_byte((raw_left <= BLOCK_MAX) ? 8'd1 : 8'd0, 1'b1);
      due_byte(cnt[7:0], 1'b1);
      due_byte(cnt[15:8], 1'b1);
      due_byte(~cnt[7:0], 1'b1);
      due_byte(~cnt[15:8], 1'b1);
      blk_left = cnt;
    end
    due_byte(b, 1'b1);
    adler_a = (adler_a + b) % 65521;
    adler_b = (adler_b + adler_a) % 65521;
    if (blk_left > 0) blk_left--;
    if (raw_left > 0) raw_left--;
  endtask

  // Signature, IHDR and the head of IDAT for a new image.
  task automatic open_image();
    logic [31:0] nblk;
    img_w = clamp_dim(reg_w, MAX_W);
    img_h = clamp_dim(reg_h, MAX_H);
    raw_left = 27'(img_h * (img_w * 4 + 1));
    nblk = (32'(raw_left) + BLOCK_MAX - 1) / BLOCK_MAX;
    idat_len = 2 + nblk * 5 + 32'(raw_left) + 4;
    due_word(32'h89504e47, 1'b0);
    due_word(32'h0d0a1a0a, 1'b0);
    due_word(32'd13, 1'b0);
    due_chunk_type("IHDR");
    due_word(32'(img_w), 1'b1);
    due_word(32'(img_h), 1'b1);
    due_byte(8'd8, 1'b1);
    due_byte(8'd6, 1'b1);
    due_byte(8'd0, 1'b1);
    due_byte(8'd0, 1'b1);
    due_byte(8'd0, 1'b1);
    due_word(~run_crc, 1'b0);
    due_word(idat_len, 1'b0);
    due_chunk_type("IDAT");
    due_byte(8'h78, 1'b1);
    due_byte(8'h01, 1'b1);
    adler_a = 1;
    adler_b = 0;
    col = 0;
    blk_left = 0;
    in_image = 1'b1;
  endtask

  // All stream bytes caused by one pixel byte.
  task automatic predict_png_bytes(input logic [7:0] px);
    int n;
    if (!in_image) open_image();
    if (col == 0) due_raw(8'd0);
    due_raw(px);
    col++;
    if (col >= img_w * 4) col = 0;
    if (raw_left == 0) begin
      due_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
      due_word(~run_crc, 1'b0);
      due_word(32'd0, 1'b0);
      due_chunk_type("IEND");
      due_word(~run_crc, 1'b0);
      png_bytes_due[png_bytes_due.size() - 1].image_end = 1'b1;
      in_image = 1'b0;
      col = 0;
      blk_left = 0;
    end
    n = png_bytes_due.size() - 1;
    png_bytes_due[n].run_last = 1'b1;
  endtask

  // Track requests on all three channels at each rising edge.
  always @(posedge clk) begin
    png_tb_pkg::png_byte_t want;
    if (rst) begin
      png_bytes_due.delete();
      reg_w = 1; reg_h = 1; img_w = 1; img_h = 1;
      in_image = 1'b0; col = 0; blk_left = 0; raw_left = 0; idat_len = 0;
      adler_a = 1; adler_b = 0; run_crc = 32'hffffffff;
      failures <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == png_tb_pkg::REG_WIDTH) reg_w = cfg_data;
        else if (cfg_index == png_tb_pkg::REG_HEIGHT) reg_h = cfg_data;
      end
      if (s_tvalid && s_tready) predict_png_bytes(s_tdata);
      if (m_tvalid && m_tready) begin
        if (png_bytes_due.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %b end %b", $time,
                   m_tdata, m_tlast, m_tuser);
          failures <= failures + 1;
        end else begin
          want = png_bytes_due.pop_front();
          if (want.out_byte !== m_tdata || want.run_last !== m_tlast ||
              want.image_end !== m_tuser) begin
            if (want.out_byte !== m_tdata)
              $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, m_tdata);
            if (want.run_last !== m_tlast)
              $display("%0t: run_last expected %b actual %b", $time, want.run_last, m_tlast);
            if (want.image_end !== m_tuser)
              $display("%0t: image_end expected %b actual %b", $time, want.image_end, m_tuser);
            failures <= failures + 1;
          end
        end
      end
    end
    pending <= png_bytes_due.size();
  end

endmodule

FILE: test/png_stored_deflate_encoder_core_test.sv
// Stimulus, receiver stalls and verdict for the PNG stored-deflate encoder.
module png_stored_deflate_encoder_core_test;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = png_tb_pkg::REG_WIDTH;
  logic [12:0] cfg_data = 13'd0;
  int          failures;
  int          pending;

  int pixels_sent = 0;
  int images_sent = 0;
  int burst_left = 0;
  int idle_count = 0;
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;
  logic hold_done = 1'b0;

  always #5 clk = ~clk;

  png_stored_deflate_encoder_core uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  png_stream_monitor mon (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures, .pending
  );

  // Watchdog on cycles with no request on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("Timeout: no request for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Receiver: stretches of steady, light, medium and heavy stalling, plus one long hold-off.
  initial begin
    int mode;
    int len;
    int held;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        hold_active = 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      repeat (len) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // One pixel byte, with random gaps between bursts.
  task automatic send_pixel(input logic [7:0] v);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // Stop offering and wait until every due byte has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A whole image of random bytes; a pause for the drain may be placed inside.
  task automatic send_image(input int nbytes, input int pause_at);
    for (int i = 0; i < nbytes; i++) begin
      if (i == pause_at) drain();
      send_pixel(8'($urandom_range(0, 255)));
    end
    images_sent++;
  endtask

  function automatic int dim_of(input logic [12:0] v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  initial begin
    logic [12:0] w, h;
    int paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size (one pixel), with extreme byte values.
    send_pixel(8'h00); send_pixel(8'hff); send_pixel(8'h55); send_pixel(8'haa);
    images_sent++;
    drain();

    // Zero width and height count as one; spare indexes are ignored.
    write_reg(png_tb_pkg::REG_WIDTH, 13'd0);
    write_reg(png_tb_pkg::REG_HEIGHT, 13'd0);
    write_reg(png_tb_pkg::REG_SPARE0, 13'h1fff);
    write_reg(png_tb_pkg::REG_SPARE1, 13'h1555);
    send_pixel(8'hff); send_pixel(8'h00); send_pixel(8'h80); send_pixel(8'h01);
    images_sent++;
    drain();

    // Two by two with every byte bit toggled.
    write_reg(png_tb_pkg::REG_WIDTH, 13'd2);
    write_reg(png_tb_pkg::REG_HEIGHT, 13'd2);
    for (int i = 0; i < 16; i++) send_pixel((i % 2 == 0) ? 8'(1 << (i / 2)) : ~8'(1 << (i / 2)));
    images_sent++;
    drain();

    // Long receiver hold-off while the sender keeps offering a six by four image.
    write_reg(png_tb_pkg::REG_WIDTH, 13'd6);
    write_reg(png_tb_pkg::REG_HEIGHT, 13'd4);
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    send_image(6 * 4 * 4, -1);
    drain();

    // Random small images, one of them with a pause for a full drain.
    paused = 0;
    while (pixels_sent < 350) begin
      w = 13'($urandom_range(1, 6));
      h = 13'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) w = 13'd0;
      if ($urandom_range(0, 9) == 0) h = 13'd0;
      write_reg(png_tb_pkg::REG_WIDTH, w);
      write_reg(png_tb_pkg::REG_HEIGHT, h);
      if (!paused && dim_of(w, 4096) * dim_of(h, 4096) > 2) begin
        send_image(dim_of(w, 4096) * dim_of(h, 4096) * 4, 5);
        paused = 1;
      end else begin
        send_image(dim_of(w, 4096) * dim_of(h, 4096) * 4, -1);
      end
      drain();
    end

    $display("Sent %0d pixel bytes in %0d images from 1x1 up to 6x4, zero sizes and spare",
             pixels_sent, images_sent);
    $display("indexes, bursty input, receiver stalls, a long hold-off and a mid-image drain.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
